// ===== sv/uvsc_pkg.sv =====
// Shared types, register map and reset values for the UV sensor compensation unit.
package uvsc_pkg;

	localparam int CNT_W  = 16;
	localparam int PROD_W = 2 * CNT_W;
	localparam int FRAC_W = 14;
	localparam int CEIL_W = PROD_W + 1 - FRAC_W;
	localparam int IDX_SHIFT = 17;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int REG_IDX_W = 3;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [CEIL_W-1:0] ceil_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_UVA_VISIBLE = 3'd0,
		REG_UVA_IR      = 3'd1,
		REG_UVB_VISIBLE = 3'd2,
		REG_UVB_IR      = 3'd3,
		REG_UVA_WEIGHT  = 3'd4,
		REG_UVB_WEIGHT  = 3'd5
	} reg_idx_t;

	localparam cnt_t RST_UVA_VISIBLE = 16'd36372;
	localparam cnt_t RST_UVA_IR      = 16'd21791;
	localparam cnt_t RST_UVB_VISIBLE = 16'd48333;
	localparam cnt_t RST_UVB_IR      = 16'd28508;
	localparam cnt_t RST_UVA_WEIGHT  = 16'd24512;
	localparam cnt_t RST_UVB_WEIGHT  = 16'd43470;

	typedef struct packed {
		cnt_t uva_visible_coef;
		cnt_t uva_ir_coef;
		cnt_t uvb_visible_coef;
		cnt_t uvb_ir_coef;
		cnt_t uva_weight;
		cnt_t uvb_weight;
	} cfg_t;

	typedef struct packed {
		logic adv;
		logic valid;
	} pipe_ctl_t;

endpackage

// ===== sv/uvsc_if.sv =====
// Valid/ready channel interfaces for sensor items and result items.
interface uvsc_in_if;
	logic          valid;
	logic          ready;
	uvsc_pkg::cnt_t raw_uva;
	uvsc_pkg::cnt_t raw_uvb;
	uvsc_pkg::cnt_t raw_comp_one;
	uvsc_pkg::cnt_t raw_comp_two;
	uvsc_pkg::cnt_t raw_dark;

	modport source (output valid, raw_uva, raw_uvb, raw_comp_one, raw_comp_two, raw_dark,
		input ready);
	modport sink (input valid, raw_uva, raw_uvb, raw_comp_one, raw_comp_two, raw_dark,
		output ready);
endinterface

interface uvsc_out_if;
	logic          valid;
	logic          ready;
	uvsc_pkg::cnt_t uva_comp;
	uvsc_pkg::cnt_t uvb_comp;
	uvsc_pkg::cnt_t uv_index;

	modport source (output valid, uva_comp, uvb_comp, uv_index, input ready);
	modport sink (input valid, uva_comp, uvb_comp, uv_index, output ready);
endinterface

// ===== sv/uv_sensor_compensation_unit.sv =====
// Top level of the UV sensor compensation unit.
//
// Usage:
//   sensor : sink channel, one item of five raw 16-bit counts per handshake.
//   result : source channel, one item per sensor item (uva_comp, uvb_comp,
//            uv_index in Q8.8), in order.
//   APB    : six 16-bit registers at byte addresses 0..20, write at any time
//            the pipeline is empty; pready is tied high, reads return values.
// Items pass through registers s1 to s6. Throughput is one item per cycle
// while result is not stalled; the two 16x16 multiplier rows (compensation
// products and index weights) each take a stage of their own.
// The whole pipeline moves as one: when result holds a valid item that is not
// taken, every stage holds and sensor.ready drops, so no item is lost or
// repeated. Empty stages are filled while the output waits only once it drains.
// Reset clears all valid bits and loads the default coefficients and weights.
module uv_sensor_compensation_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	uvsc_in_if.sink                     sensor,
	uvsc_out_if.source                  result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [uvsc_pkg::ADDR_W-1:0] paddr,
	input  logic [uvsc_pkg::DATA_W-1:0] pwdata,
	output logic [uvsc_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	uvsc_pkg::cfg_t      cfg;
	uvsc_pkg::pipe_ctl_t ctl_in, ctl_mid;
	logic                adv;
	logic                valid_s4, valid_s6;
	uvsc_pkg::cnt_t      uva_s4, uvb_s4;

	assign adv          = !valid_s6 || result.ready;
	assign sensor.ready = adv;
	assign ctl_in       = '{adv: adv, valid: sensor.valid};
	assign ctl_mid      = '{adv: adv, valid: valid_s4};
	assign result.valid = valid_s6;

	uvsc_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	uvsc_comp_pipe u_comp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl_in),
		.raw_uva      (sensor.raw_uva),
		.raw_uvb      (sensor.raw_uvb),
		.raw_comp_one (sensor.raw_comp_one),
		.raw_comp_two (sensor.raw_comp_two),
		.raw_dark     (sensor.raw_dark),
		.cfg          (cfg),
		.valid_s4     (valid_s4),
		.uva_s4       (uva_s4),
		.uvb_s4       (uvb_s4)
	);

	uvsc_index_pipe u_index (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_mid),
		.uva_s4   (uva_s4),
		.uvb_s4   (uvb_s4),
		.cfg      (cfg),
		.valid_s6 (valid_s6),
		.uva_s6   (result.uva_comp),
		.uvb_s6   (result.uvb_comp),
		.idx_s6   (result.uv_index)
	);

endmodule

// ===== sv/uvsc_cfg_regs.sv =====
// APB-style register file holding the compensation coefficients and index weights.
module uvsc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [uvsc_pkg::ADDR_W-1:0] paddr,
	input  logic [uvsc_pkg::DATA_W-1:0] pwdata,
	output logic [uvsc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output uvsc_pkg::cfg_t              cfg
);

	uvsc_pkg::cfg_t cfg_q;
	logic [uvsc_pkg::REG_IDX_W-1:0] idx;
	uvsc_pkg::cnt_t wval;
	uvsc_pkg::cnt_t rval;

	assign idx    = paddr[uvsc_pkg::ADDR_W-1:2];
	assign wval   = pwdata[uvsc_pkg::CNT_W-1:0];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.uva_visible_coef <= uvsc_pkg::RST_UVA_VISIBLE;
			cfg_q.uva_ir_coef      <= uvsc_pkg::RST_UVA_IR;
			cfg_q.uvb_visible_coef <= uvsc_pkg::RST_UVB_VISIBLE;
			cfg_q.uvb_ir_coef      <= uvsc_pkg::RST_UVB_IR;
			cfg_q.uva_weight       <= uvsc_pkg::RST_UVA_WEIGHT;
			cfg_q.uvb_weight       <= uvsc_pkg::RST_UVB_WEIGHT;
		end else if (psel && penable && pwrite) begin
			case (idx)
				uvsc_pkg::REG_UVA_VISIBLE: cfg_q.uva_visible_coef <= wval;
				uvsc_pkg::REG_UVA_IR:      cfg_q.uva_ir_coef      <= wval;
				uvsc_pkg::REG_UVB_VISIBLE: cfg_q.uvb_visible_coef <= wval;
				uvsc_pkg::REG_UVB_IR:      cfg_q.uvb_ir_coef      <= wval;
				uvsc_pkg::REG_UVA_WEIGHT:  cfg_q.uva_weight       <= wval;
				uvsc_pkg::REG_UVB_WEIGHT:  cfg_q.uvb_weight       <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			uvsc_pkg::REG_UVA_VISIBLE: rval = cfg_q.uva_visible_coef;
			uvsc_pkg::REG_UVA_IR:      rval = cfg_q.uva_ir_coef;
			uvsc_pkg::REG_UVB_VISIBLE: rval = cfg_q.uvb_visible_coef;
			uvsc_pkg::REG_UVB_IR:      rval = cfg_q.uvb_ir_coef;
			uvsc_pkg::REG_UVA_WEIGHT:  rval = cfg_q.uva_weight;
			uvsc_pkg::REG_UVB_WEIGHT:  rval = cfg_q.uvb_weight;
			default:                   rval = '0;
		endcase
	end

	assign prdata = {{(uvsc_pkg::DATA_W-uvsc_pkg::CNT_W){1'b0}}, rval};

endmodule

// ===== sv/uvsc_comp_pipe.sv =====
// Dark subtraction and compensation stages s1 to s4.
module uvsc_comp_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  uvsc_pkg::pipe_ctl_t ctl,
	input  uvsc_pkg::cnt_t     raw_uva,
	input  uvsc_pkg::cnt_t     raw_uvb,
	input  uvsc_pkg::cnt_t     raw_comp_one,
	input  uvsc_pkg::cnt_t     raw_comp_two,
	input  uvsc_pkg::cnt_t     raw_dark,
	input  uvsc_pkg::cfg_t     cfg,
	output logic               valid_s4,
	output uvsc_pkg::cnt_t     uva_s4,
	output uvsc_pkg::cnt_t     uvb_s4
);

	logic valid_s1, valid_s2, valid_s3, valid_s4_q;
	uvsc_pkg::cnt_t  uva_s1, uvb_s1, c1_s1, c2_s1;
	uvsc_pkg::cnt_t  uva_s2, uvb_s2;
	uvsc_pkg::prod_t pa1_s2, pa2_s2, pb1_s2, pb2_s2;
	uvsc_pkg::cnt_t  va_s3, vb_s3;
	uvsc_pkg::ceil_t ca1_s3, cb1_s3;
	uvsc_pkg::cnt_t  uva_s4_q, uvb_s4_q;

	function automatic uvsc_pkg::cnt_t sub_floor0(input uvsc_pkg::cnt_t a,
		input uvsc_pkg::cnt_t b);
		sub_floor0 = (a > b) ? a - b : '0;
	endfunction

	function automatic uvsc_pkg::ceil_t ceil_q14(input uvsc_pkg::prod_t p);
		logic [uvsc_pkg::PROD_W:0] s;
		s = {1'b0, p} + {{(uvsc_pkg::PROD_W+1-uvsc_pkg::FRAC_W){1'b0}},
			{uvsc_pkg::FRAC_W{1'b1}}};
		ceil_q14 = s[uvsc_pkg::PROD_W:uvsc_pkg::FRAC_W];
	endfunction

	function automatic uvsc_pkg::cnt_t sub_ceil(input uvsc_pkg::cnt_t a,
		input uvsc_pkg::ceil_t b);
		logic [uvsc_pkg::CEIL_W-1:0] ax;
		ax = {{(uvsc_pkg::CEIL_W-uvsc_pkg::CNT_W){1'b0}}, a};
		sub_ceil = (ax > b) ? a - b[uvsc_pkg::CNT_W-1:0] : '0;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			valid_s4_q <= 1'b0;
		end else if (ctl.adv) begin
			valid_s1   <= ctl.valid;
			valid_s2   <= valid_s1;
			valid_s3   <= valid_s2;
			valid_s4_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			uva_s1 <= sub_floor0(raw_uva, raw_dark);
			uvb_s1 <= sub_floor0(raw_uvb, raw_dark);
			c1_s1  <= sub_floor0(raw_comp_one, raw_dark);
			c2_s1  <= sub_floor0(raw_comp_two, raw_dark);

			uva_s2 <= uva_s1;
			uvb_s2 <= uvb_s1;
			pa1_s2 <= uvsc_pkg::prod_t'(c1_s1) * uvsc_pkg::prod_t'(cfg.uva_visible_coef);
			pa2_s2 <= uvsc_pkg::prod_t'(c2_s1) * uvsc_pkg::prod_t'(cfg.uva_ir_coef);
			pb1_s2 <= uvsc_pkg::prod_t'(c1_s1) * uvsc_pkg::prod_t'(cfg.uvb_visible_coef);
			pb2_s2 <= uvsc_pkg::prod_t'(c2_s1) * uvsc_pkg::prod_t'(cfg.uvb_ir_coef);

			va_s3  <= sub_ceil(uva_s2, ceil_q14(pa2_s2));
			vb_s3  <= sub_ceil(uvb_s2, ceil_q14(pb2_s2));
			ca1_s3 <= ceil_q14(pa1_s2);
			cb1_s3 <= ceil_q14(pb1_s2);

			uva_s4_q <= sub_ceil(va_s3, ca1_s3);
			uvb_s4_q <= sub_ceil(vb_s3, cb1_s3);
		end
	end

	assign valid_s4 = valid_s4_q;
	assign uva_s4   = uva_s4_q;
	assign uvb_s4   = uvb_s4_q;

endmodule

// ===== sv/uvsc_index_pipe.sv =====
// UV index stages s5 and s6: weighted products, sum and scale.
module uvsc_index_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  uvsc_pkg::pipe_ctl_t ctl,
	input  uvsc_pkg::cnt_t     uva_s4,
	input  uvsc_pkg::cnt_t     uvb_s4,
	input  uvsc_pkg::cfg_t     cfg,
	output logic               valid_s6,
	output uvsc_pkg::cnt_t     uva_s6,
	output uvsc_pkg::cnt_t     uvb_s6,
	output uvsc_pkg::cnt_t     idx_s6
);

	localparam int SUM_W = uvsc_pkg::PROD_W + 1;
	localparam int HI_W  = SUM_W - uvsc_pkg::IDX_SHIFT;

	logic valid_s5, valid_s6_q;
	uvsc_pkg::cnt_t  uva_s5, uvb_s5, uva_s6_q, uvb_s6_q, idx_s6_q;
	uvsc_pkg::prod_t wa_s5, wb_s5;
	logic [SUM_W-1:0] sum;
	logic [HI_W-1:0]  hi;

	assign sum = {1'b0, wa_s5} + {1'b0, wb_s5};
	assign hi  = sum[SUM_W-1:uvsc_pkg::IDX_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5   <= 1'b0;
			valid_s6_q <= 1'b0;
		end else if (ctl.adv) begin
			valid_s5   <= ctl.valid;
			valid_s6_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			uva_s5 <= uva_s4;
			uvb_s5 <= uvb_s4;
			wa_s5  <= uvsc_pkg::prod_t'(uva_s4) * uvsc_pkg::prod_t'(cfg.uva_weight);
			wb_s5  <= uvsc_pkg::prod_t'(uvb_s4) * uvsc_pkg::prod_t'(cfg.uvb_weight);

			uva_s6_q <= uva_s5;
			uvb_s6_q <= uvb_s5;
			idx_s6_q <= hi;
		end
	end

	assign valid_s6 = valid_s6_q;
	assign uva_s6   = uva_s6_q;
	assign uvb_s6   = uvb_s6_q;
	assign idx_s6   = idx_s6_q;

endmodule

// ===== sv/uvsc_checker.sv =====
// Port-level assertions for the UV sensor compensation unit, with its bind.
module uvsc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           s_valid,
	input logic           s_ready,
	input logic           r_valid,
	input logic           r_ready,
	input uvsc_pkg::cnt_t uva_comp,
	input uvsc_pkg::cnt_t uvb_comp,
	input uvsc_pkg::cnt_t uv_index
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid)
		else $error("result item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> $stable(uva_comp) && $stable(uvb_comp) && $stable(uv_index))
		else $error("result item changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |-> !s_ready)
		else $error("sensor item taken while result stalled");

	a_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && uva_comp == '0 && uvb_comp == '0 |-> uv_index == '0)
		else $error("nonzero index from zero counts");

	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!r_valid |-> s_ready)
		else $error("sensor stalled with empty output");

endmodule

bind uv_sensor_compensation_unit uvsc_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_valid  (sensor.valid),
	.s_ready  (sensor.ready),
	.r_valid  (result.valid),
	.r_ready  (result.ready),
	.uva_comp (result.uva_comp),
	.uvb_comp (result.uvb_comp),
	.uv_index (result.uv_index)
);
